// File: hw/rtl/ask_fsk_psk_modulator_defines.svh
// Assertion macros for the ASK/FSK/PSK modulator
`ifndef ASK_FSK_PSK_MODULATOR_DEFINES_SVH
`define ASK_FSK_PSK_MODULATOR_DEFINES_SVH

// same-cycle implication
`define AFPM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AFPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/afpm_pkg.sv
// Shared types and constants of the ASK/FSK/PSK modulator
`timescale 1ns / 1ps
package afpm_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int QUEUE_DEPTH         = 4;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    KIND_ASK = 2'd0,
    KIND_FSK = 2'd1,
    KIND_PSK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_KIND       = 3'd0,
    REG_CARRIER    = 3'd1,
    REG_SPACE      = 3'd2,
    REG_MARK       = 3'd3,
    REG_OFFSET     = 3'd4,
    REG_COMMON     = 3'd5,
    REG_ASK_LOW    = 3'd6,
    REG_ASK_HIGH   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] carrier_step;
    logic [31:0] space_step;
    logic [31:0] mark_step;
    logic [15:0] phase_offset;
    logic [7:0]  common_gain;
    logic [7:0]  ask_low_gain;
    logic [7:0]  ask_high_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kind:          KIND_ASK,
    carrier_step:  32'd85899346,
    space_step:    32'd128849019,
    mark_step:     32'd171798692,
    phase_offset:  16'd32768,
    common_gain:   8'd1,
    ask_low_gain:  8'd1,
    ask_high_gain: 8'd8
  };

  // classified sample: amplitude and 16-bit table phase
  typedef struct packed {
    logic [7:0]  gain;
    logic [15:0] phase;
  } item_t;

  typedef struct packed {
    logic phases_zero;
  } front_stat_t;

  typedef struct packed {
    logic s1_vld;
    logic out_full;
  } back_stat_t;

endpackage

// File: hw/rtl/afpm_queue.sv
// Small register FIFO
`timescale 1ns / 1ps
module afpm_queue #(
  parameter int WIDTH = 24,
  parameter int DEPTH = afpm_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     level
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      level_r, level_nxt;
  logic             do_push, do_pop;

  assign full    = (level_r == (AW+1)'(DEPTH));
  assign empty   = (level_r == '0);
  assign level   = level_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   level_nxt = level_r + 1'b1;
      2'b01:   level_nxt = level_r - 1'b1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/afpm_front.sv
// Front end: phase accumulators and per-sample phase/gain selection
`timescale 1ns / 1ps
module afpm_front #(
  parameter int PHASE_BITS = afpm_pkg::PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  afpm_pkg::cfg_t        cfg,
  input  logic                  in_push,
  input  logic                  in_data_bit,
  input  logic                  in_last_sample,
  input  logic                  q_full,
  output logic                  q_push,
  output afpm_pkg::item_t       q_item,
  output afpm_pkg::front_stat_t stat
);
  import afpm_pkg::*;

  logic [PHASE_BITS-1:0] car_r, car_nxt, spc_r, spc_nxt, mrk_r, mrk_nxt;
  logic [15:0]           car_top, spc_top, mrk_top;
  logic                  xfer;

  assign xfer    = in_push && !q_full;
  assign q_push  = xfer;
  assign car_top = car_r[PHASE_BITS-1 -: 16];
  assign spc_top = spc_r[PHASE_BITS-1 -: 16];
  assign mrk_top = mrk_r[PHASE_BITS-1 -: 16];
  assign stat.phases_zero = (car_r == '0) && (spc_r == '0) && (mrk_r == '0);

  always_comb begin
    q_item = '0;
    case (cfg.kind)
      KIND_ASK: begin
        q_item.phase = car_top + cfg.phase_offset;
        q_item.gain  = in_data_bit ? cfg.ask_high_gain : cfg.ask_low_gain;
      end
      KIND_FSK: begin
        q_item.phase = (in_data_bit ? mrk_top : spc_top) + cfg.phase_offset;
        q_item.gain  = cfg.common_gain;
      end
      KIND_PSK: begin
        q_item.phase = car_top + {in_data_bit, 15'd0};
        q_item.gain  = cfg.common_gain;
      end
      default: q_item = '0;
    endcase
  end

  always_comb begin
    car_nxt = car_r;
    spc_nxt = spc_r;
    mrk_nxt = mrk_r;
    if (xfer) begin
      if (in_last_sample) begin
        car_nxt = '0;
        spc_nxt = '0;
        mrk_nxt = '0;
      end else begin
        car_nxt = car_r + PHASE_BITS'(cfg.carrier_step);
        spc_nxt = spc_r + PHASE_BITS'(cfg.space_step);
        mrk_nxt = mrk_r + PHASE_BITS'(cfg.mark_step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_r <= '0;
      spc_r <= '0;
      mrk_r <= '0;
    end else begin
      car_r <= car_nxt;
      spc_r <= spc_nxt;
      mrk_r <= mrk_nxt;
    end
  end

endmodule

// File: hw/rtl/afpm_back.sv
// Back end: quarter-wave sine ROM, gain multiply and result FIFO
`timescale 1ns / 1ps
module afpm_back #(
  parameter int SINE_TABLE_BITS = afpm_pkg::SINE_TABLE_BITS_DEF,
  parameter int QDEPTH          = afpm_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  afpm_pkg::item_t      q_item,
  output logic                 q_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic signed [23:0]   out_sample_value,
  output afpm_pkg::back_stat_t stat
);
  import afpm_pkg::*;

  localparam int TB        = SINE_TABLE_BITS;
  localparam int TableLen  = 1 << TB;
  localparam int TableLen2 = 2 * TableLen;
  localparam int LW        = $clog2(QDEPTH) + 1;
  localparam longint unsigned FactDiv [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef logic [15:0] rom_t [TableLen];

  function automatic rom_t build_rom();
    rom_t           rom;
    longint unsigned x, x2, term;
    longint          sum, v;
    for (int k = 0; k < TableLen; k++) begin
      x    = (HALF_PI_Q30 * (2 * longint'(k) + 1)) / TableLen2;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / FactDiv[n-1];
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum * 32767 + (longint'(1) << 29)) >>> 30;
      rom[k] = v[15:0];
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [TB-1:0]       idx;
  logic [15:0]         rom_q_r;
  logic                neg_r;
  logic [7:0]          gain_r;
  logic                s1_vld_r;
  logic [LW-1:0]       out_level;
  logic                out_full;
  logic [LW:0]         committed;
  logic signed [16:0]  sine_s;
  logic signed [25:0]  prod;

  // credit: results in the FIFO plus the one in the ROM stage
  assign committed = {1'b0, out_level} + (LW+1)'(s1_vld_r);
  assign q_pop     = !q_empty && (committed < (LW+1)'(QDEPTH));

  always_comb begin
    idx = q_item.phase[13 -: TB];
    if (q_item.phase[14]) begin
      idx = ~idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rom_q_r <= SineRom[idx];
      neg_r   <= q_item.phase[15];
      gain_r  <= q_item.gain;
    end
  end

  assign sine_s = neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
  assign prod   = $signed({1'b0, gain_r}) * sine_s;

  afpm_queue #(
    .WIDTH (24),
    .DEPTH (QDEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s1_vld_r),
    .wdata (prod[23:0]),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_sample_value),
    .empty (out_empty),
    .level (out_level)
  );

  assign stat.s1_vld   = s1_vld_r;
  assign stat.out_full = out_full;

endmodule

// File: hw/rtl/ask_fsk_psk_modulator.sv
// Top level of the binary ASK/FSK/PSK carrier modulator
//
//   channel  ports                                   transfer when
//   input    in_push in_data_bit in_last_sample      in_push & !in_full
//   result   out_pop out_sample_value                out_pop & !out_empty
//   config   cfg_we cfg_index cfg_wdata              cfg_we
//
// One sample per clock sustained while out_pop keeps pace. A result reaches the output ports
// through the classify queue, sine ROM read and gain multiply into the result FIFO.
// The result FIFO holds 4 samples; when it backs up, the 4-entry classify queue
// fills and in_full rises. Reset is synchronous, active low, and clears the phase
// accumulators, both queues and the registers to their defaults.
`timescale 1ns / 1ps
`include "ask_fsk_psk_modulator_defines.svh"
module ask_fsk_psk_modulator #(
  parameter int PHASE_BITS      = afpm_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = afpm_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_data_bit,
  input  logic                in_last_sample,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [23:0]  out_sample_value,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import afpm_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  item_t       front_item, back_item;
  logic        q_push, q_pop, q_full, q_empty;
  logic [$clog2(QUEUE_DEPTH):0] q_level;
  front_stat_t front_stat;
  back_stat_t  back_stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_e'(cfg_index))
        REG_KIND:     cfg_nxt.kind          = kind_e'(cfg_wdata[1:0]);
        REG_CARRIER:  cfg_nxt.carrier_step  = cfg_wdata;
        REG_SPACE:    cfg_nxt.space_step    = cfg_wdata;
        REG_MARK:     cfg_nxt.mark_step     = cfg_wdata;
        REG_OFFSET:   cfg_nxt.phase_offset  = cfg_wdata[15:0];
        REG_COMMON:   cfg_nxt.common_gain   = cfg_wdata[7:0];
        REG_ASK_LOW:  cfg_nxt.ask_low_gain  = cfg_wdata[7:0];
        REG_ASK_HIGH: cfg_nxt.ask_high_gain = cfg_wdata[7:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;

  afpm_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_data_bit    (in_data_bit),
    .in_last_sample (in_last_sample),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (front_item),
    .stat           (front_stat)
  );

  afpm_queue #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (front_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (back_item),
    .empty (q_empty),
    .level (q_level)
  );

  afpm_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .QDEPTH          (QUEUE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (back_item),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_sample_value (out_sample_value),
    .stat             (back_stat)
  );

  `AFPM_ASSERT_NEXT(a_burst_clear, clk, rst_n, in_push && !in_full && in_last_sample, front_stat.phases_zero, "phases not cleared after last sample")
  `AFPM_ASSERT_NOW(a_no_overflow, clk, rst_n, back_stat.s1_vld, !back_stat.out_full, "ROM stage result with full output FIFO")
  `AFPM_ASSERT_NEXT(a_result_shows, clk, rst_n, back_stat.s1_vld, !out_empty, "multiplied sample did not reach output")
  `AFPM_ASSERT_NOW(a_full_level, clk, rst_n, q_full, q_level == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH), "full without full level")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ASK/FSK/PSK modulator: directed table, random bursts, idling
module tb_top;
  import afpm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DELAY = 4;
  localparam int ITEMS_PER_PHASE = 143;
  localparam int NUM_PHASES = 9;
  localparam int HOLD_CYCLES = 100;
  localparam int TBL_N = 1 << SINE_TABLE_BITS_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] carrier_step;
    logic [31:0] space_step;
    logic [31:0] mark_step;
    logic [15:0] phase_offset;
    logic [7:0]  common_gain;
    logic [7:0]  ask_low_gain;
    logic [7:0]  ask_high_gain;
  } mod_settings_t;

  typedef struct {
    bit                 is_write;
    reg_idx_e           idx;
    logic [31:0]        wdata;
    bit                 data_bit;
    bit                 last;
    bit                 typed;
    logic signed [23:0] sample;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic               in_data_bit;
  logic               in_last_sample;
  logic               out_empty;
  logic               out_pop;
  logic signed [23:0] out_sample_value;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;

  int                 sine_rom[TBL_N];
  mod_settings_t      mod_set;
  logic [31:0]        car_acc, spc_acc, mrk_acc;
  logic signed [23:0] pending_samples[$];
  stim_row_t          dir_rows[$];
  int                 fail_count;
  int                 cycle_count;
  int                 tx_idle_pct;
  int                 rx_stall_pct;
  bit                 hold_req;
  int                 hold_left;

  ask_fsk_psk_modulator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_bit      (in_data_bit),
    .in_last_sample   (in_last_sample),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_sample_value (out_sample_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // quarter-wave Q1.15 table from a truncated Q30 Taylor series
  function automatic void build_sine();
    longint unsigned x, x2, term, den;
    longint sum;
    for (int k = 0; k < TBL_N; k++) begin
      x = (HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * TBL_N);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        den = 64'((2 * n) * (2 * n + 1));
        term = ((term * x2) >> 30) / den;
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      sine_rom[k] = int'((sum * 32767 + (64'sd1 <<< 29)) >>> 30);
    end
  endfunction

  function automatic int sine_at(input logic [15:0] p);
    logic [SINE_TABLE_BITS_DEF-1:0] idx;
    int v;
    idx = p[13 -: SINE_TABLE_BITS_DEF];
    if (p[14]) idx = SINE_TABLE_BITS_DEF'(TBL_N - 1 - idx);
    v = sine_rom[idx];
    return p[15] ? -v : v;
  endfunction

  function automatic void reset_modulator();
    mod_set.kind          = CFG_RESET.kind;
    mod_set.carrier_step  = CFG_RESET.carrier_step;
    mod_set.space_step    = CFG_RESET.space_step;
    mod_set.mark_step     = CFG_RESET.mark_step;
    mod_set.phase_offset  = CFG_RESET.phase_offset;
    mod_set.common_gain   = CFG_RESET.common_gain;
    mod_set.ask_low_gain  = CFG_RESET.ask_low_gain;
    mod_set.ask_high_gain = CFG_RESET.ask_high_gain;
    car_acc = '0;
    spc_acc = '0;
    mrk_acc = '0;
  endfunction

  function automatic void apply_reg(input reg_idx_e idx, input logic [31:0] val);
    case (idx)
      REG_KIND:     mod_set.kind          = val[1:0];
      REG_CARRIER:  mod_set.carrier_step  = val;
      REG_SPACE:    mod_set.space_step    = val;
      REG_MARK:     mod_set.mark_step     = val;
      REG_OFFSET:   mod_set.phase_offset  = val[15:0];
      REG_COMMON:   mod_set.common_gain   = val[7:0];
      REG_ASK_LOW:  mod_set.ask_low_gain  = val[7:0];
      REG_ASK_HIGH: mod_set.ask_high_gain = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [23:0] predict_sample(input bit b, input bit l);
    logic [15:0] ph;
    int gain;
    int prod;
    ph = '0;
    gain = 0;
    case (mod_set.kind)
      KIND_ASK: begin
        ph = car_acc[31:16] + mod_set.phase_offset;
        gain = b ? mod_set.ask_high_gain : mod_set.ask_low_gain;
      end
      KIND_FSK: begin
        ph = (b ? mrk_acc[31:16] : spc_acc[31:16]) + mod_set.phase_offset;
        gain = mod_set.common_gain;
      end
      KIND_PSK: begin
        ph = car_acc[31:16] + (b ? 16'h8000 : 16'h0000);
        gain = mod_set.common_gain;
      end
      default: ;
    endcase
    prod = gain * sine_at(ph);
    if (l) begin
      car_acc = '0;
      spc_acc = '0;
      mrk_acc = '0;
    end else begin
      car_acc += mod_set.carrier_step;
      spc_acc += mod_set.space_step;
      mrk_acc += mod_set.mark_step;
    end
    return prod[23:0];
  endfunction

  function automatic logic [7:0] rand_gain();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    return $urandom >> $urandom_range(24);
  endfunction

  function automatic void add_write(input reg_idx_e idx, input logic [31:0] val);
    stim_row_t r;
    r = '{is_write: 1'b1, idx: idx, wdata: val, data_bit: 1'b0, last: 1'b0,
          typed: 1'b0, sample: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_sample(input bit b, input bit l, input bit typed, input int want);
    stim_row_t r;
    r = '{is_write: 1'b0, idx: REG_KIND, wdata: '0, data_bit: b, last: l,
          typed: typed, sample: want[23:0]};
    dir_rows.push_back(r);
  endfunction

  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (PIPE_DELAY) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic send_item(input bit b, input bit l, input bit typed,
                           input logic signed [23:0] want);
    logic signed [23:0] pred;
    in_push <= 1'b1;
    in_data_bit <= b;
    in_last_sample <= l;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pred = predict_sample(b, l);
    pending_samples.push_back(typed ? want : pred);
  endtask

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // result transfer check
  always @(posedge clk) begin
    logic signed [23:0] want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_samples.size() == 0) begin
        report_fail($sformatf("unexpected sample %0d", out_sample_value));
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_value !== want)
          report_fail($sformatf("sample_value expected %0d got %0d", want, out_sample_value));
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  initial begin
    out_pop = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    logic [31:0] v_car, v_spc, v_mrk;
    logic [15:0] v_off;
    logic [7:0]  v_com, v_lo, v_hi;
    logic [1:0]  v_kind;
    int          gap;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data_bit = 1'b0;
    in_last_sample = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    fail_count = 0;
    cycle_count = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b0;
    build_sine();
    reset_modulator();

    // phases at zero: results follow straight from the table ends
    add_sample(0, 1, 1, -25);
    add_sample(1, 1, 1, -200);
    add_sample(0, 0, 0, 0);
    add_sample(1, 0, 0, 0);
    add_sample(1, 1, 0, 0);
    add_write(REG_OFFSET, 32'h0000_4000);
    add_write(REG_ASK_LOW, 32'd255);
    add_write(REG_ASK_HIGH, 32'd0);
    add_sample(0, 1, 1, 8355585);
    add_sample(1, 1, 1, 0);
    add_write(REG_OFFSET, 32'h0000_C000);
    add_sample(0, 1, 1, -8355585);
    add_write(REG_KIND, 32'(KIND_PSK));
    add_write(REG_COMMON, 32'd255);
    add_sample(0, 1, 1, 6375);
    add_sample(1, 1, 1, -6375);
    add_sample(0, 0, 0, 0);
    add_sample(1, 1, 0, 0);
    add_write(REG_KIND, 32'(KIND_FSK));
    add_write(REG_SPACE, 32'h4000_0000);
    add_write(REG_MARK, 32'hC000_0000);
    add_write(REG_OFFSET, 32'h0);
    add_sample(0, 0, 1, 6375);
    add_sample(0, 0, 1, 8355585);
    add_sample(1, 1, 1, -6375);
    add_sample(1, 0, 0, 0);
    add_write(REG_KIND, 32'(KIND_UNUSED));
    add_sample(0, 0, 1, 0);
    add_sample(1, 1, 1, 0);
    add_write(REG_CARRIER, 32'hFFFF_FFFF);
    add_write(REG_KIND, 32'(KIND_ASK));
    add_write(REG_OFFSET, 32'h0000_FFFF);
    add_write(REG_COMMON, 32'd0);
    add_sample(0, 0, 0, 0);
    add_sample(1, 0, 0, 0);
    add_sample(1, 0, 0, 0);
    add_sample(0, 1, 0, 0);
    add_write(REG_CARRIER, 32'h0);
    add_write(REG_KIND, 32'(KIND_PSK));
    add_write(REG_COMMON, 32'd128);
    add_sample(1, 0, 0, 0);
    add_sample(0, 1, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) cfg_write(dir_rows[i].idx, dir_rows[i].wdata);
      else send_item(dir_rows[i].data_bit, dir_rows[i].last, dir_rows[i].typed,
                     dir_rows[i].sample);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
      endcase
      if (ph == 0) begin
        v_car = '1; v_spc = '1; v_mrk = '1; v_off = '1;
        v_com = '1; v_lo = '1; v_hi = '1;
      end else if (ph == 1) begin
        v_car = '0; v_spc = '0; v_mrk = '0; v_off = '0;
        v_com = 8'd255; v_lo = 8'd0; v_hi = 8'd255;
      end else begin
        v_car = rand_step(); v_spc = rand_step(); v_mrk = rand_step();
        v_off = 16'($urandom);
        v_com = rand_gain(); v_lo = rand_gain(); v_hi = rand_gain();
      end
      v_kind = (ph == 3) ? KIND_UNUSED : 2'(ph % 3);
      cfg_write(REG_KIND, 32'(v_kind));
      cfg_write(REG_CARRIER, v_car);
      cfg_write(REG_SPACE, v_spc);
      cfg_write(REG_MARK, v_mrk);
      cfg_write(REG_OFFSET, 32'(v_off));
      cfg_write(REG_COMMON, 32'(v_com));
      cfg_write(REG_ASK_LOW, 32'(v_lo));
      cfg_write(REG_ASK_HIGH, 32'(v_hi));

      // long receiver hold-off while the sender keeps pushing
      if (ph == 4) hold_req = 1'b1;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item($urandom_range(1), ($urandom_range(15) == 0), 1'b0, '0);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
          in_push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        // sender pause until every transfer has drained
        if (ph == 2 && i == ITEMS_PER_PHASE / 2) wait_idle();
      end
    end

    wait_idle();
    repeat (2 * PIPE_DELAY) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/afpm_pkg.sv
hw/rtl/afpm_queue.sv
hw/rtl/afpm_front.sv
hw/rtl/afpm_back.sv
hw/rtl/ask_fsk_psk_modulator.sv
tb/tb_top.sv
